@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

@@ design/lcdpwm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdpwm_pkg
// shared types and constants of the lcd nibble and pwm port sequencer
// ----------------------------------------------------------------------------
package lcdpwm_pkg;

  // input modes
  localparam logic [1:0] MODE_INSTR_HI = 2'd0;
  localparam logic [1:0] MODE_INSTR    = 2'd1;
  localparam logic [1:0] MODE_DATA     = 2'd2;
  localparam logic [1:0] MODE_TICK     = 2'd3;

  // configuration register indexes
  localparam logic CFG_PWM_BIT   = 1'b0;
  localparam logic CFG_DUTY_STEP = 1'b1;

  // image bits
  localparam logic [7:0] RS_BIT      = 8'h01;
  localparam logic [7:0] RW_BIT      = 8'h02;
  localparam logic [7:0] E_BIT       = 8'h04;
  localparam logic [7:0] NIBBLE_MASK = 8'hf0;
  localparam logic [7:0] LOW_MASK    = 8'h0f;

  // pwm constants
  localparam logic [6:0]  PWM_PERIOD = 7'd100;
  localparam logic [6:0]  DUTY_WRAP  = 7'd99;
  localparam logic [6:0]  DUTY_RESET = 7'd10;
  localparam logic [31:0] TICK_US    = 32'd100;

  localparam logic [2:0]  PWM_BIT_RESET   = 3'd3;
  localparam logic [15:0] DUTY_STEP_RESET = 16'd20;

  // seven images per nibble, numbered 0..6
  localparam logic [2:0] SUB_LAST = 3'd6;
  localparam logic [2:0] SUB_RW0  = 3'd0;
  localparam logic [2:0] SUB_RS   = 3'd1;
  localparam logic [2:0] SUB_NIB  = 3'd2;
  localparam logic [2:0] SUB_E1   = 3'd3;
  localparam logic [2:0] SUB_E0   = 3'd4;
  localparam logic [2:0] SUB_RS1  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LCD  = 3'b010,
    ST_TICK = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic lcd_step;
    logic tick;
  } cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic lcd_final;
    logic out_free;
  } sts_t;

endpackage

@@ design/lcdpwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcdpwm_ctrl
// sequencer state machine: takes an item, paces lcd images and the tick step
// ----------------------------------------------------------------------------
module lcdpwm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcdpwm_pkg::sts_t  sts,
  output lcdpwm_pkg::cmd_t  cmd
);

  lcdpwm_pkg::state_t state_r, state_nxt;

  assign in_ready = (state_r == lcdpwm_pkg::ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      lcdpwm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = sts.in_is_tick ? lcdpwm_pkg::ST_TICK : lcdpwm_pkg::ST_LCD;
        end
      end
      lcdpwm_pkg::ST_LCD: begin
        if (sts.out_free) begin
          cmd.lcd_step = 1'b1;
          if (sts.lcd_final) begin
            state_nxt = lcdpwm_pkg::ST_IDLE;
          end
        end
      end
      lcdpwm_pkg::ST_TICK: begin
        // tick waits for a free slot even if it ends up emitting nothing
        if (sts.out_free) begin
          cmd.tick  = 1'b1;
          state_nxt = lcdpwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcdpwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcdpwm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ design/lcdpwm_dp.sv @@
// ----------------------------------------------------------------------------
// lcdpwm_dp
// datapath: port image, pwm phase and duty, timestamps, config, output register
// ----------------------------------------------------------------------------
module lcdpwm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_value,
  input  logic [31:0]       in_now_ms,
  input  logic [31:0]       in_now_us,
  input  logic              cfg_valid,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  lcdpwm_pkg::cmd_t  cmd,
  output lcdpwm_pkg::sts_t  sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_port_image,
  output logic              out_last
);

  logic [2:0]  pwm_bit_r;
  logic [15:0] duty_step_ms_r;

  logic [1:0]  mode_r;
  logic [7:0]  value_r;
  logic [31:0] now_ms_r;
  logic [31:0] now_us_r;

  logic [7:0]  image_r, image_nxt;
  logic [31:0] last_tick_us_r;
  logic [31:0] last_step_ms_r;
  logic [6:0]  phase_r;
  logic [6:0]  duty_r;

  logic [2:0]  sub_r;
  logic        nib_r;

  logic        out_valid_r;
  logic [7:0]  out_image_r;
  logic        out_last_r;

  logic        is_data, data_nib2, final_img;
  logic [7:0]  nib_bits, lcd_img;
  logic [7:0]  mask, tick_img;
  logic [31:0] diff_us, diff_ms;
  logic        tick_hit, step_hit, phase_top, phase_match, tick_emit;
  logic [6:0]  duty_inc;
  logic        emit;

  assign is_data  = (mode_r == lcdpwm_pkg::MODE_DATA);
  assign data_nib2 = is_data && nib_r;
  assign nib_bits = nib_r ? {value_r[3:0], 4'b0000} : (value_r & lcdpwm_pkg::NIBBLE_MASK);
  assign final_img = (sub_r == lcdpwm_pkg::SUB_LAST) &&
                     (nib_r || (mode_r == lcdpwm_pkg::MODE_INSTR_HI));

  always_comb begin
    unique case (sub_r)
      lcdpwm_pkg::SUB_RW0:
        lcd_img = data_nib2 ? (image_r | lcdpwm_pkg::RS_BIT) : (image_r & ~lcdpwm_pkg::RW_BIT);
      lcdpwm_pkg::SUB_RS: begin
        if (data_nib2) begin
          lcd_img = image_r & ~lcdpwm_pkg::RW_BIT;
        end else if (is_data) begin
          lcd_img = image_r | lcdpwm_pkg::RS_BIT;
        end else begin
          lcd_img = image_r & ~lcdpwm_pkg::RS_BIT;
        end
      end
      lcdpwm_pkg::SUB_NIB: lcd_img = (image_r & lcdpwm_pkg::LOW_MASK) | nib_bits;
      lcdpwm_pkg::SUB_E1:  lcd_img = image_r | lcdpwm_pkg::E_BIT;
      lcdpwm_pkg::SUB_E0:  lcd_img = image_r & ~lcdpwm_pkg::E_BIT;
      lcdpwm_pkg::SUB_RS1: lcd_img = image_r | lcdpwm_pkg::RS_BIT;
      default:             lcd_img = image_r | lcdpwm_pkg::RW_BIT;
    endcase
  end

  // pwm tick
  assign mask        = 8'h01 << pwm_bit_r;
  assign diff_us     = now_us_r - last_tick_us_r;
  assign diff_ms     = now_ms_r - last_step_ms_r;
  assign tick_hit    = (diff_us >= lcdpwm_pkg::TICK_US);
  assign step_hit    = (diff_ms >= {16'b0, duty_step_ms_r});
  assign phase_top   = (phase_r == lcdpwm_pkg::PWM_PERIOD);
  assign phase_match = (phase_r == duty_r);
  assign tick_img    = phase_top ? (image_r | mask) : (image_r & ~mask);
  assign tick_emit   = tick_hit && (phase_top || phase_match);
  assign duty_inc    = duty_r + 7'd1;

  assign emit = cmd.lcd_step || (cmd.tick && tick_emit);

  always_comb begin
    image_nxt = image_r;
    if (cmd.lcd_step) begin
      image_nxt = lcd_img;
    end else if (cmd.tick && tick_emit) begin
      image_nxt = tick_img;
    end
  end

  assign sts.in_is_tick = (in_mode == lcdpwm_pkg::MODE_TICK);
  assign sts.lcd_final  = final_img;
  assign sts.out_free   = !out_valid_r || out_ready;

  // captured item and output register payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      value_r  <= in_value;
      now_ms_r <= in_now_ms;
      now_us_r <= in_now_us;
    end
    if (emit) begin
      out_image_r <= image_nxt;
      out_last_r  <= cmd.tick || final_img;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_bit_r      <= lcdpwm_pkg::PWM_BIT_RESET;
      duty_step_ms_r <= lcdpwm_pkg::DUTY_STEP_RESET;
      image_r        <= '0;
      last_tick_us_r <= '0;
      last_step_ms_r <= '0;
      phase_r        <= '0;
      duty_r         <= lcdpwm_pkg::DUTY_RESET;
      sub_r          <= '0;
      nib_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          lcdpwm_pkg::CFG_PWM_BIT:   pwm_bit_r      <= cfg_data[2:0];
          lcdpwm_pkg::CFG_DUTY_STEP: duty_step_ms_r <= cfg_data;
          default: ;
        endcase
      end
      image_r <= image_nxt;
      if (cmd.load) begin
        sub_r <= '0;
        nib_r <= 1'b0;
      end else if (cmd.lcd_step) begin
        if (sub_r == lcdpwm_pkg::SUB_LAST) begin
          sub_r <= '0;
          nib_r <= 1'b1;
        end else begin
          sub_r <= sub_r + 3'd1;
        end
      end
      if (cmd.tick) begin
        if (tick_hit) begin
          last_tick_us_r <= now_us_r;
          // period end wraps the phase straight back to one
          phase_r <= phase_top ? 7'd1 : (phase_r + 7'd1);
        end
        if (step_hit) begin
          last_step_ms_r <= now_ms_r;
          duty_r <= (duty_inc == lcdpwm_pkg::DUTY_WRAP) ? 7'd1 : duty_inc;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_port_image = out_image_r;
  assign out_last       = out_last_r;

endmodule

@@ design/lcd_nibble_and_pwm_port_sequencer.sv @@
// ----------------------------------------------------------------------------
// lcd_nibble_and_pwm_port_sequencer
// builds shift-register port images for a 4-bit lcd plus a breathing pwm bit
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_mode, in_value, in_now_ms, in_now_us
// out      output     out_valid / out_ready  out_port_image, out_last
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an lcd item gives 7 or 14 images, one image per cycle from the nibble
// sequencer while the output slot is free; a tick gives at most one image.
// in_ready is high only while the sequencer is idle; the next item may be
// accepted while the last image still sits in the output register.
// a stalled output holds the sequencer; cfg_ready is always high.
// synchronous active-low reset clears image, pwm state and config to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_nibble_and_pwm_port_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_value,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_port_image,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  lcdpwm_pkg::cmd_t cmd;
  lcdpwm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  lcdpwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcdpwm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mode        (in_mode),
    .in_value       (in_value),
    .in_now_ms      (in_now_ms),
    .in_now_us      (in_now_us),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_port_image (out_port_image),
    .out_last       (out_last)
  );

  // busy right after taking an item
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // an image is only produced into a free output slot
  `ASSERT_SAME(a_emit_into_free_slot, cmd.lcd_step || cmd.tick, sts.out_free)
  // a non-final image means more of the same item is still coming
  `ASSERT_SAME(a_pending_images_busy, out_valid && !out_last, !in_ready)

endmodule

@@ dv/lcd_port_checker.sv @@
// ----------------------------------------------------------------------------
// lcd_port_checker
// watches the in, out and cfg channels of the lcd nibble and pwm port
// sequencer, predicts every port image from accepted items and compares each
// image transfer against the oldest prediction
// ----------------------------------------------------------------------------
module lcd_port_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_value,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_now_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_port_image,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          open_count
);

  typedef struct packed {
    logic [7:0] port_image;
    logic       last;
  } port_result_t;

  port_result_t image_q[$];
  logic [7:0]   burst_imgs[$];

  // shadow of the block's state and registers
  logic [7:0]  image_model;
  logic [31:0] tick_us_mark;
  logic [31:0] step_ms_mark;
  logic [6:0]  pwm_phase;
  logic [6:0]  pwm_duty;
  logic [2:0]  pwm_sel;
  logic [15:0] duty_step;

  int shown;

  initial begin
    fail_count = 0;
    open_count = 0;
    shown      = 0;
  end

  task automatic snap();
    burst_imgs.push_back(image_model);
  endtask

  task automatic shift_nibble(input logic [7:0] nib, input logic is_data,
                              input logic data_nib2);
    if (data_nib2) begin
      image_model = image_model | lcdpwm_pkg::RS_BIT;
      snap();
      image_model = image_model & ~lcdpwm_pkg::RW_BIT;
      snap();
    end else begin
      image_model = image_model & ~lcdpwm_pkg::RW_BIT;
      snap();
      image_model = is_data ? (image_model | lcdpwm_pkg::RS_BIT)
                            : (image_model & ~lcdpwm_pkg::RS_BIT);
      snap();
    end
    image_model = (image_model & ~lcdpwm_pkg::NIBBLE_MASK) |
                  (nib & lcdpwm_pkg::NIBBLE_MASK);
    snap();
    image_model = image_model | lcdpwm_pkg::E_BIT;
    snap();
    image_model = image_model & ~lcdpwm_pkg::E_BIT;
    snap();
    image_model = image_model | lcdpwm_pkg::RS_BIT;
    snap();
    image_model = image_model | lcdpwm_pkg::RW_BIT;
    snap();
  endtask

  task automatic pwm_tick(input logic [31:0] ms, input logic [31:0] us);
    logic [7:0]  mask;
    logic [31:0] us_gap;
    logic [31:0] ms_gap;
    mask   = 8'h01 << pwm_sel;
    us_gap = us - tick_us_mark;
    ms_gap = ms - step_ms_mark;
    if (us_gap >= lcdpwm_pkg::TICK_US) begin
      tick_us_mark = us;
      if (pwm_phase == lcdpwm_pkg::PWM_PERIOD) begin
        image_model = image_model | mask;
        snap();
        pwm_phase = '0;
      end else if (pwm_phase == pwm_duty) begin
        image_model = image_model & ~mask;
        snap();
      end
      pwm_phase = pwm_phase + 7'd1;
    end
    // duty moves after the compare above
    if (ms_gap >= {16'd0, duty_step}) begin
      step_ms_mark = ms;
      pwm_duty     = pwm_duty + 7'd1;
      if (pwm_duty == lcdpwm_pkg::DUTY_WRAP) pwm_duty = 7'd1;
    end
  endtask

  task automatic predict_images(input logic [1:0] mode, input logic [7:0] value,
                                input logic [31:0] ms, input logic [31:0] us);
    port_result_t r;
    burst_imgs.delete();
    case (mode)
      lcdpwm_pkg::MODE_INSTR_HI: begin
        shift_nibble(value, 1'b0, 1'b0);
      end
      lcdpwm_pkg::MODE_INSTR: begin
        shift_nibble(value, 1'b0, 1'b0);
        shift_nibble(value << 4, 1'b0, 1'b0);
      end
      lcdpwm_pkg::MODE_DATA: begin
        shift_nibble(value, 1'b1, 1'b0);
        shift_nibble(value << 4, 1'b1, 1'b1);
      end
      default: begin
        pwm_tick(ms, us);
      end
    endcase
    foreach (burst_imgs[i]) begin
      r.port_image = burst_imgs[i];
      r.last       = (i == burst_imgs.size() - 1);
      image_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    port_result_t want;
    if (!rst_n) begin
      image_model  = '0;
      tick_us_mark = '0;
      step_ms_mark = '0;
      pwm_phase    = '0;
      pwm_duty     = lcdpwm_pkg::DUTY_RESET;
      pwm_sel      = lcdpwm_pkg::PWM_BIT_RESET;
      duty_step    = lcdpwm_pkg::DUTY_STEP_RESET;
      image_q.delete();
    end else begin
      // an image leaving now always belongs to an earlier item
      if (out_valid && out_ready) begin
        if (image_q.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected image transfer: image %02h last %0d",
                     out_port_image, out_last);
          end
        end else begin
          want = image_q.pop_front();
          if (out_port_image !== want.port_image || out_last !== want.last) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("mismatch: image exp %02h got %02h, last exp %0d got %0d",
                       want.port_image, out_port_image, want.last, out_last);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lcdpwm_pkg::CFG_PWM_BIT) pwm_sel = cfg_data[2:0];
        else duty_step = cfg_data;
      end
      if (in_valid && in_ready)
        predict_images(in_mode, in_value, in_now_ms, in_now_us);
    end
    open_count = image_q.size();
  end

endmodule

@@ dv/lcd_nibble_and_pwm_port_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// lcd_nibble_and_pwm_port_sequencer_tb
// drives lcd bytes and pwm ticks into the port sequencer with random gaps and
// output stalls, across several register settings; the checker beside the
// block predicts and compares every image, this top gives the verdict
// ----------------------------------------------------------------------------
module lcd_nibble_and_pwm_port_sequencer_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = lcdpwm_pkg::MODE_INSTR_HI;
  logic [7:0]  in_value = '0;
  logic [31:0] in_now_ms = '0;
  logic [31:0] in_now_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_port_image;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = lcdpwm_pkg::CFG_PWM_BIT;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int open_count;
  int cycles = 0;

  // no idling on a side while its flag is set
  logic in_steady = 1'b0;
  logic out_steady = 1'b0;

  logic [31:0] us_clock = '0;
  logic [31:0] ms_clock = '0;

  lcd_nibble_and_pwm_port_sequencer u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_now_ms     (in_now_ms),
    .in_now_us     (in_now_us),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_port_image(out_port_image),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lcd_port_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_now_ms     (in_now_ms),
    .in_now_us     (in_now_us),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_port_image(out_port_image),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .open_count    (open_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // image sink with random stalls
  initial begin
    int  stall;
    logic took;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
      if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [7:0] value,
                           input logic [31:0] ms, input logic [31:0] us);
    int   gap;
    logic took;
    gap = in_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_value  <= value;
    in_now_ms <= ms;
    in_now_us <= us;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    if ($urandom_range(0, 29) == 0) in_steady = !in_steady;
  endtask

  // mostly well-spaced ticks, some too early, a few wild jumps in time
  task automatic send_tick();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      us_clock = $urandom;
      ms_clock = $urandom;
    end else begin
      if (pick < 20) us_clock = us_clock + $urandom_range(0, 99);
      else us_clock = us_clock + $urandom_range(100, 300);
      ms_clock = ms_clock + $urandom_range(0, 40);
    end
    send_item(lcdpwm_pkg::MODE_TICK, 8'($urandom_range(0, 255)), ms_clock, us_clock);
  endtask

  task automatic random_run(input int count, input int tick_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_tick();
      else send_item(2'($urandom_range(lcdpwm_pkg::MODE_INSTR_HI, lcdpwm_pkg::MODE_DATA)),
                     8'($urandom_range(0, 255)), $urandom, $urandom);
    end
  endtask

  // ticks may leave no image, so give the block time to finish after the queue drains
  task automatic settle();
    logic done;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      done = (open_count == 0);
      @(posedge clk);
    end while (!done);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] pwm_word, input logic [15:0] step_word);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= lcdpwm_pkg::CFG_PWM_BIT;
    cfg_data  <= pwm_word;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_index <= lcdpwm_pkg::CFG_DUTY_STEP;
    cfg_data  <= step_word;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every lcd mode at the byte extremes and with mixed bit patterns, times ignored
    send_item(lcdpwm_pkg::MODE_INSTR_HI, 8'h00, 32'h0, 32'h0);
    send_item(lcdpwm_pkg::MODE_INSTR_HI, 8'hff, 32'hffffffff, 32'hffffffff);
    send_item(lcdpwm_pkg::MODE_INSTR, 8'h00, 32'h0, 32'h0);
    send_item(lcdpwm_pkg::MODE_INSTR, 8'hff, 32'hffffffff, 32'hffffffff);
    send_item(lcdpwm_pkg::MODE_INSTR, 8'ha5, 32'h0, 32'h0);
    send_item(lcdpwm_pkg::MODE_DATA, 8'h00, 32'h0, 32'h0);
    send_item(lcdpwm_pkg::MODE_DATA, 8'hff, 32'hffffffff, 32'hffffffff);
    send_item(lcdpwm_pkg::MODE_DATA, 8'h5a, 32'h0, 32'h0);
    send_item(lcdpwm_pkg::MODE_INSTR_HI, 8'h3c, 32'h0, 32'h0);

    // tick edges: too soon, exactly on time, full range, wrap around zero
    send_item(lcdpwm_pkg::MODE_TICK, 8'hff, 32'd0, 32'd0);
    send_item(lcdpwm_pkg::MODE_TICK, 8'h00, 32'd19, 32'd99);
    send_item(lcdpwm_pkg::MODE_TICK, 8'h00, 32'd20, 32'd100);
    send_item(lcdpwm_pkg::MODE_TICK, 8'h00, 32'hffffffff, 32'hffffffff);
    send_item(lcdpwm_pkg::MODE_TICK, 8'h00, 32'd19, 32'd99);
    send_item(lcdpwm_pkg::MODE_TICK, 8'h00, 32'd20, 32'd150);

    // walk the phase up to the duty with time frozen in ms
    us_clock = 32'd150;
    ms_clock = 32'd20;
    for (int i = 0; i < 11; i++) begin
      us_clock = us_clock + 32'd100;
      send_item(lcdpwm_pkg::MODE_TICK, 8'h00, ms_clock, us_clock);
    end

    random_run(45, 60);
    settle();

    // top pwm bit with junk upper bits, duty moving on every tick
    write_regs(16'hffff, 16'h0000);
    random_run(50, 80);
    settle();

    // pwm on the rs bit, slowest duty sweep
    write_regs(16'h0000, 16'hffff);
    random_run(45, 60);
    settle();

    write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 5)));
    random_run(44, 70);
    settle();

    if (fail_count == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/lcdpwm_pkg.sv
design/lcdpwm_ctrl.sv
design/lcdpwm_dp.sv
design/lcd_nibble_and_pwm_port_sequencer.sv
dv/lcd_port_checker.sv
dv/lcd_nibble_and_pwm_port_sequencer_tb.sv
